// ----- hdl/fnv_pkg.sv -----
// ----------------------------------------------------------------------------
// fnv_pkg
// Shared constants, codes and the FNV-1a byte step for the hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package fnv_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  // Input opcodes; code 7 has no meaning and changes nothing
  typedef enum logic [2:0] {
    OP_ADD_BYTE  = 3'd0,
    OP_ADD_WORD  = 3'd1,
    OP_UNO_BYTE  = 3'd2,
    OP_UNO_WORD  = 3'd3,
    OP_INCORP    = 3'd4,
    OP_RST_ORD   = 3'd5,
    OP_RST_UNO   = 3'd6
  } op_t;

  // Commands from the controller to the datapath, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_SETUP_ORD,   // acc = running hash, bytes = operand
    CMD_SETUP_INC,   // acc = running hash, bytes = xor then sum
    CMD_SETUP_FRESH, // acc = basis, bytes = operand
    CMD_SETUP_UNH,   // acc = basis, bytes = xor then sum
    CMD_STEP,        // one FNV-1a byte step
    CMD_WB_ORD,      // running hash = acc
    CMD_WB_INC,      // running hash = acc, clear unordered pair
    CMD_FOLD,        // fold acc into xor and sum
    CMD_WB_UNH,      // unordered hash = acc
    CMD_RST_ORD,     // running hash = basis
    CMD_CLR_UNO,     // clear unordered pair
    CMD_OUT          // load result registers
  } cmd_t;

  // One FNV-1a step; the prime is 2^40 + 0x1b3, so shifts and adds suffice
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // Eight steps over a word, low byte first; used for constants only
  function automatic logic [63:0] fnv_word(input logic [63:0] h, input logic [63:0] w);
    logic [63:0] acc;
    acc = h;
    for (int i = 0; i < 8; i++) begin
      acc = fnv_step(acc, w[8*i +: 8]);
    end
    return acc;
  endfunction

  // Unordered hash of a cleared pair (xor = basis, sum = zero)
  localparam logic [63:0] UNH_CLEAR = fnv_word(fnv_word(FNV_BASIS, FNV_BASIS), 64'd0);

endpackage

`default_nettype wire

// ----- hdl/fnv_dp.sv -----
// ----------------------------------------------------------------------------
// fnv_dp
// Hash datapath: state registers, byte step unit and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_dp
  import fnv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [63:0] data_word,
  output logic [63:0]      ordered_hash,
  output logic [63:0]      unordered_hash
);

  logic [63:0]  running_hash;
  logic [63:0]  unordered_xor;
  logic [63:0]  unordered_sum;
  logic [63:0]  unh;
  logic [63:0]  acc;
  logic [127:0] bytes;

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= FNV_BASIS;
      unordered_xor <= FNV_BASIS;
      unordered_sum <= 64'd0;
      unh           <= UNH_CLEAR;
    end else begin
      unique case (cmd)
        CMD_WB_ORD:  running_hash <= acc;
        CMD_WB_INC: begin
          running_hash  <= acc;
          unordered_xor <= FNV_BASIS;
          unordered_sum <= 64'd0;
          unh           <= UNH_CLEAR;
        end
        CMD_FOLD: begin
          unordered_xor <= unordered_xor ^ acc;
          unordered_sum <= unordered_sum + acc;
        end
        CMD_WB_UNH:  unh <= acc;
        CMD_RST_ORD: running_hash <= FNV_BASIS;
        CMD_CLR_UNO: begin
          unordered_xor <= FNV_BASIS;
          unordered_sum <= 64'd0;
          unh           <= UNH_CLEAR;
        end
        default: ;
      endcase
    end
  end

  // Step unit: accumulator and byte shift line, low byte first
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_SETUP_ORD: begin
        acc   <= running_hash;
        bytes <= {64'd0, data_word};
      end
      CMD_SETUP_INC: begin
        acc   <= running_hash;
        bytes <= {unordered_sum, unordered_xor};
      end
      CMD_SETUP_FRESH: begin
        acc   <= FNV_BASIS;
        bytes <= {64'd0, data_word};
      end
      CMD_SETUP_UNH: begin
        acc   <= FNV_BASIS;
        bytes <= {unordered_sum, unordered_xor};
      end
      CMD_STEP: begin
        acc   <= fnv_step(acc, bytes[7:0]);
        bytes <= {8'd0, bytes[127:8]};
      end
      default: ;
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT) begin
      ordered_hash   <= running_hash;
      unordered_hash <= unh;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fnv_ctrl.sv -----
// ----------------------------------------------------------------------------
// fnv_ctrl
// Sequencer: decodes each transaction and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_ctrl
  import fnv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  output logic             out_valid,
  input  wire logic        out_stall,
  output cmd_t             cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_STEP  = 7'b0000010,
    S_WB    = 7'b0000100,
    S_USET  = 7'b0001000,
    S_USTEP = 7'b0010000,
    S_UWB   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [3:0]  cnt, cnt_next;
  op_t         op_q;
  logic        accept;
  logic        out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Next state, step count and command
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_ADD_BYTE: begin
              cmd = CMD_SETUP_ORD;   cnt_next = 4'd0;  state_next = S_STEP;
            end
            OP_ADD_WORD: begin
              cmd = CMD_SETUP_ORD;   cnt_next = 4'd7;  state_next = S_STEP;
            end
            OP_UNO_BYTE: begin
              cmd = CMD_SETUP_FRESH; cnt_next = 4'd0;  state_next = S_STEP;
            end
            OP_UNO_WORD: begin
              cmd = CMD_SETUP_FRESH; cnt_next = 4'd7;  state_next = S_STEP;
            end
            OP_INCORP: begin
              cmd = CMD_SETUP_INC;   cnt_next = 4'd15; state_next = S_STEP;
            end
            OP_RST_ORD: begin
              cmd = CMD_RST_ORD;     state_next = S_DONE;
            end
            OP_RST_UNO: begin
              cmd = CMD_CLR_UNO;     state_next = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_STEP: begin
        cmd      = CMD_STEP;
        cnt_next = cnt - 4'd1;
        if (cnt == 4'd0) state_next = S_WB;
      end
      S_WB: begin
        unique case (op_q)
          OP_INCORP: begin
            cmd = CMD_WB_INC; state_next = S_DONE;
          end
          OP_UNO_BYTE, OP_UNO_WORD: begin
            cmd = CMD_FOLD;   state_next = S_USET;
          end
          default: begin
            cmd = CMD_WB_ORD; state_next = S_DONE;
          end
        endcase
      end
      S_USET: begin
        cmd        = CMD_SETUP_UNH;
        cnt_next   = 4'd15;
        state_next = S_USTEP;
      end
      S_USTEP: begin
        cmd      = CMD_STEP;
        cnt_next = cnt - 4'd1;
        if (cnt == 4'd0) state_next = S_UWB;
      end
      S_UWB: begin
        cmd        = CMD_WB_UNH;
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to be free
        if (out_free) begin
          cmd        = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd == CMD_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Opcode of the transaction in progress
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op_t'(opcode);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fnv1a_ordered_unordered_hash.sv -----
// ----------------------------------------------------------------------------
// fnv1a_ordered_unordered_hash
// 64-bit FNV-1a running hash with an order-independent XOR/sum accumulator.
// ----------------------------------------------------------------------------
// One transaction is handled at a time, by the single byte-step unit that
// does one FNV-1a step per cycle. Add byte and add word step the running
// hash over the operand; incorporate runs sixteen steps over xor then sum;
// unordered byte and unordered word hash the operand fresh, then run a
// sixteen-step refresh of the unordered result. Reset ops and the unused
// opcode 7 run no steps. The result sits in an output register, so the
// next transaction is accepted while it waits; a further result then
// waits until that register is taken.
`default_nettype none

module fnv1a_ordered_unordered_hash
  import fnv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [63:0] data_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      ordered_hash,
  output logic [63:0]      unordered_hash
);

  cmd_t cmd;

  fnv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fnv_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .data_word      (data_word),
    .ordered_hash   (ordered_hash),
    .unordered_hash (unordered_hash)
  );

endmodule

`default_nettype wire

// ----- hdl/fnv_checker.sv -----
// ----------------------------------------------------------------------------
// fnv_checker
// Port-level checks for the hash block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] ordered_hash,
  input wire logic [63:0] unordered_hash
);

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  // a new result only appears at the end of a busy period
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(ordered_hash) && $stable(unordered_hash)))
    else $error("stalled result changed");

endmodule

bind fnv1a_ordered_unordered_hash fnv_checker u_fnv_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .ordered_hash   (ordered_hash),
  .unordered_hash (unordered_hash)
);

`default_nettype wire
